[sv/stxd_pkg.sv]
// ----------------------------------------------------------------------------
// stxd_pkg
// Shared types and constants for the STX/length/command/ETX deframer.
// ----------------------------------------------------------------------------
package stxd_pkg;

  localparam logic [7:0]  STX_BYTE    = 8'h02;
  localparam logic [7:0]  ETX_BYTE    = 8'h03;

  // Hard ceiling on the payload length, applied on top of max_length.
  localparam logic [15:0] MAX_PAYLOAD = 16'd256;

  localparam int unsigned MAXLEN_W    = 9;
  localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = 9'd256;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_OK   = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [15:0] frame_length;
    logic [15:0] command;
    logic [7:0]  payload_index;
    logic [7:0]  payload_byte;
    kind_t       kind;
  } result_t;

endpackage

[sv/stxd_parser.sv]
// ----------------------------------------------------------------------------
// stxd_parser
// Byte-wise frame parser: state update and result build for one item.
// ----------------------------------------------------------------------------
module stxd_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [stxd_pkg::MAXLEN_W-1:0] cfg_wdata,
  input  logic                          take,
  input  logic [7:0]                    in_byte,
  output logic                          res_valid,
  output stxd_pkg::result_t             res
);

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_LEN  = 3'd1,
    PH_CMD  = 3'd2,
    PH_DATA = 3'd3,
    PH_END  = 3'd4
  } phase_t;

  phase_t                        phase, phase_next;
  logic [8:0]                    field_count, field_count_next;
  logic [15:0]                   length_reg, length_reg_next;
  logic [15:0]                   command_reg, command_reg_next;
  logic [stxd_pkg::MAXLEN_W-1:0] max_length;

  logic [15:0] limit;
  logic [15:0] len_full;
  logic [15:0] idx_inc;

  // effective limit: smaller of the register and the hard ceiling
  always_comb begin
    limit = {7'd0, max_length};
    if (stxd_pkg::MAX_PAYLOAD < limit) begin
      limit = stxd_pkg::MAX_PAYLOAD;
    end
  end

  assign len_full = {in_byte, length_reg[7:0]};
  assign idx_inc  = {7'd0, field_count} + 16'd1;

  always_comb begin
    phase_next       = phase;
    field_count_next = field_count;
    length_reg_next  = length_reg;
    command_reg_next = command_reg;
    res_valid        = 1'b0;
    res.kind          = stxd_pkg::KIND_DATA;
    res.payload_byte  = 8'd0;
    res.payload_index = 8'd0;
    res.command       = command_reg;
    res.frame_length  = length_reg;
    unique case (phase)
      PH_HUNT: begin
        if (in_byte == stxd_pkg::STX_BYTE) begin
          phase_next       = PH_LEN;
          field_count_next = 9'd0;
        end
      end
      PH_LEN: begin
        if (field_count == 9'd0) begin
          length_reg_next  = {8'd0, in_byte};
          field_count_next = 9'd1;
        end else begin
          length_reg_next  = len_full;
          field_count_next = 9'd0;
          if (len_full > limit) begin
            phase_next       = PH_HUNT;
            res_valid        = 1'b1;
            res.kind         = stxd_pkg::KIND_ERR;
            res.command      = 16'd0;
            res.frame_length = len_full;
          end else begin
            phase_next = PH_CMD;
          end
        end
      end
      PH_CMD: begin
        if (field_count == 9'd0) begin
          command_reg_next = {8'd0, in_byte};
          field_count_next = 9'd1;
        end else begin
          command_reg_next = {in_byte, command_reg[7:0]};
          field_count_next = 9'd0;
          phase_next       = (length_reg != 16'd0) ? PH_DATA : PH_END;
        end
      end
      PH_DATA: begin
        res_valid         = 1'b1;
        res.kind          = stxd_pkg::KIND_DATA;
        res.payload_byte  = in_byte;
        res.payload_index = field_count[7:0];  // wraps past 255
        if (idx_inc >= length_reg) begin
          field_count_next = 9'd0;
          phase_next       = PH_END;
        end else begin
          field_count_next = idx_inc[8:0];
        end
      end
      PH_END: begin
        phase_next       = PH_HUNT;
        field_count_next = 9'd0;
        res_valid        = 1'b1;
        res.kind         = (in_byte == stxd_pkg::ETX_BYTE) ? stxd_pkg::KIND_OK
                                                           : stxd_pkg::KIND_ERR;
      end
      default: begin
        phase_next       = PH_HUNT;
        field_count_next = 9'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      field_count <= 9'd0;
      length_reg  <= 16'd0;
      command_reg <= 16'd0;
      max_length  <= stxd_pkg::MAXLEN_RESET;
    end else begin
      if (cfg_we) begin
        max_length <= cfg_wdata;
      end
      if (take) begin
        phase       <= phase_next;
        field_count <= field_count_next;
        length_reg  <= length_reg_next;
        command_reg <= command_reg_next;
      end
    end
  end

  // the idle (hunt) phase holds a cleared counter
  a_hunt_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HUNT) |-> (field_count == 9'd0))
    else $error("field_count not cleared while hunting");

  // payload counter always below the received length
  a_data_idx: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> ({7'd0, field_count} < length_reg))
    else $error("payload index past frame length");

endmodule

[sv/stxd_out_buf.sv]
// ----------------------------------------------------------------------------
// stxd_out_buf
// Result register with a skid stage; input side ready is registered.
// ----------------------------------------------------------------------------
module stxd_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  stxd_pkg::result_t in_data,
  output logic              in_ready,
  output logic              out_valid,
  output stxd_pkg::result_t out_data,
  input  logic              out_ready
);

  logic              main_valid;
  logic              skid_valid;
  stxd_pkg::result_t main_data;
  stxd_pkg::result_t skid_data;
  logic              pop;

  assign in_ready  = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;
  assign pop       = main_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop || !main_valid) begin
        if (skid_valid) begin
          main_data  <= skid_data;
          main_valid <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          main_data  <= in_data;
          main_valid <= in_valid;
        end
      end else if (in_valid && !skid_valid) begin
        skid_data  <= in_data;
        skid_valid <= 1'b1;
      end
    end
  end

  a_skid_needs_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid holds an item ahead of the output register");

  a_skid_moves_up: assert property (@(posedge clk) disable iff (rst)
    (pop && skid_valid) |=> (main_valid && !skid_valid &&
                             main_data == $past(skid_data)))
    else $error("skid item not promoted in order");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (pop && !skid_valid && !in_valid) |=> !main_valid)
    else $error("output item repeated after drain");

endmodule

[sv/stx_len_cmd_etx_deframer.sv]
// ----------------------------------------------------------------------------
// stx_len_cmd_etx_deframer
// Parses STX / length / command / payload / ETX frames one byte per item.
// ----------------------------------------------------------------------------
//
//   channel  | dir | tdata (low bit first)                          | tuser
//   ---------+-----+------------------------------------------------+------
//   s_axis   | in  | rx_byte[7:0]                                   | -
//   m_axis   | out | payload_byte, payload_index, command,          | kind
//            |     | frame_length (48 bits)                         |
//   cfg      | in  | max_length[8:0], written when cfg_we is high   | -
//
// One byte item is taken per clock while s_tready is high; the parser state
// updates in the cycle the item is accepted and any result is registered
// in the output buffer. Each item produces zero or one result.
// A two-entry output (register plus skid) keeps s_tready high while one
// result waits, so a stalled m_tready only blocks input once both fill.
// rst (synchronous) returns the parser to hunting, max_length to 256.
// ----------------------------------------------------------------------------
module stx_len_cmd_etx_deframer (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata,    // max_length
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,      // [7:0] rx_byte
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,      // [7:0] payload_byte, [15:8] payload_index,
                                    // [31:16] command, [47:32] frame_length
  output logic [1:0]  m_tuser       // [1:0] kind: 0 data, 1 frame ok, 2 error
);

  logic              take;
  logic              res_valid;
  stxd_pkg::result_t res;
  logic              buf_ready;
  stxd_pkg::result_t out_res;

  // an item is consumed whenever the buffer can absorb a possible result
  assign s_tready = buf_ready;
  assign take     = s_tvalid && buf_ready;

  stxd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .take      (take),
    .in_byte   (s_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  stxd_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (take && res_valid),
    .in_data   (res),
    .in_ready  (buf_ready),
    .out_valid (m_tvalid),
    .out_data  (out_res),
    .out_ready (m_tready)
  );

  assign m_tdata = {out_res.frame_length, out_res.command,
                    out_res.payload_index, out_res.payload_byte};
  assign m_tuser = out_res.kind;

endmodule
